// ===== hdl/i2cdbw_pkg.sv =====
// Shared types, codes and helpers for the I2C display byte writer.
`default_nettype none

package i2cdbw_pkg;

  // Sequencer stages of one write transfer
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_START  = 4'd1,
    ST_ADDR   = 4'd2,
    ST_ADDR_A = 4'd3,
    ST_CTRL   = 4'd4,
    ST_CTRL_A = 4'd5,
    ST_PAY    = 4'd6,
    ST_PAY_A  = 4'd7,
    ST_STOP   = 4'd8
  } stage_e;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_DEV_ADDR = 2'd0,
    REG_CMD_CTRL = 2'd1,
    REG_DAT_CTRL = 2'd2
  } reg_idx_e;

  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
  localparam logic [7:0] CMD_CTRL_RESET = 8'h00;
  localparam logic [7:0] DAT_CTRL_RESET = 8'h40;

  // Last phase of a byte: setup phase plus 8 bits of 3 phases
  localparam logic [4:0] BYTE_LAST_PHASE = 5'd24;

  // Position inside a bit for each byte phase, (phase - 1) mod 3
  localparam logic [1:0] BIT_POS_LUT [32] = '{
    2'd0,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0
  };

  // Bit positions inside one bit slot
  localparam logic [1:0] BIT_SET_DATA = 2'd0;
  localparam logic [1:0] BIT_CLK_HIGH = 2'd1;

  typedef struct packed {
    logic       command;
    logic       is_data;
    logic [7:0] payload_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_driven;
    logic busy_res;
    logic nack_seen;
    logic send_taken;
  } out_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] cmd_ctrl;
    logic [7:0] dat_ctrl;
  } cfg_t;

  // Line levels: clock, data, data driven
  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  typedef struct packed {
    logic       busy;
    stage_e     stage;
    logic [4:0] phase;
    logic [7:0] shift;
    logic [7:0] pay;
    logic       is_data;
    logic       nack;
    logic [1:0] ins;
    lines_t     lines;
  } state_t;

  // Stop condition phases: clock low/data low, clock high, data high
  function automatic lines_t stop_lines(logic [1:0] n);
    lines_t l;
    case (n)
      2'd0:    l = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
      2'd1:    l = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      default: l = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/i2cdbw_step.sv =====
// Next-state and result logic for one item of the I2C byte writer sequencer.
`default_nettype none

module i2cdbw_step import i2cdbw_pkg::*; (
  input  state_t cur_i,
  input  in_t    item_i,
  input  cfg_t   cfg_i,
  output state_t nxt_o,
  output out_t   res_o
);

  logic   taken;
  state_t nxt;
  logic [1:0] bit_pos;

  assign bit_pos = BIT_POS_LUT[cur_i.phase];

  always_comb begin
    nxt   = cur_i;
    taken = 1'b0;
    if (item_i.command) begin
      // send request, taken only while idle
      if (!cur_i.busy) begin
        nxt.pay     = item_i.payload_byte;
        nxt.is_data = item_i.is_data;
        nxt.nack    = 1'b0;
        nxt.ins     = 2'd0;
        nxt.busy    = 1'b1;
        nxt.stage   = ST_START;
        nxt.phase   = 5'd0;
        taken       = 1'b1;
      end
    end else if (cur_i.busy) begin
      case (cur_i.stage)
        ST_START: begin
          if (cur_i.phase == 5'd0) begin
            nxt.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            nxt.phase = 5'd1;
          end else if (cur_i.phase == 5'd1) begin
            nxt.lines = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
            nxt.phase = 5'd2;
          end else begin
            nxt.lines = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            nxt.stage = ST_ADDR;
            nxt.phase = 5'd0;
            nxt.shift = cfg_i.dev_addr;
          end
        end
        ST_ADDR, ST_CTRL, ST_PAY: begin
          // byte: setup phase, then 3 phases per bit, MSB first
          if (cur_i.phase == 5'd0) begin
            nxt.lines = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
          end else if (bit_pos == BIT_SET_DATA) begin
            nxt.lines = '{scl: 1'b0, sda: cur_i.shift[7], drv: 1'b1};
          end else if (bit_pos == BIT_CLK_HIGH) begin
            nxt.lines.scl = 1'b1;
            nxt.lines.drv = 1'b1;
          end else begin
            nxt.lines.scl = 1'b0;
            nxt.lines.drv = 1'b1;
            nxt.shift     = {cur_i.shift[6:0], 1'b0};
          end
          if (cur_i.phase >= BYTE_LAST_PHASE) begin
            nxt.phase = 5'd0;
            case (cur_i.stage)
              ST_ADDR: nxt.stage = ST_ADDR_A;
              ST_CTRL: nxt.stage = ST_CTRL_A;
              default: nxt.stage = ST_PAY_A;
            endcase
          end else begin
            nxt.phase = cur_i.phase + 5'd1;
          end
        end
        ST_ADDR_A, ST_CTRL_A, ST_PAY_A: begin
          if (cur_i.ins != 2'd0) begin
            // stop inserted after a NACK
            nxt.lines = stop_lines(cur_i.ins - 2'd1);
            nxt.ins   = (cur_i.ins == 2'd3) ? 2'd0 : cur_i.ins + 2'd1;
          end else if (cur_i.phase == 5'd0) begin
            // release data, clock high, sample acknowledge
            nxt.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
            if (item_i.sda_in) begin
              nxt.nack = 1'b1;
              nxt.ins  = 2'd1;
            end
            nxt.phase = 5'd1;
          end else begin
            nxt.lines.scl = 1'b0;
            nxt.phase     = 5'd0;
            case (cur_i.stage)
              ST_ADDR_A: begin
                nxt.stage = ST_CTRL;
                nxt.shift = cur_i.is_data ? cfg_i.dat_ctrl : cfg_i.cmd_ctrl;
              end
              ST_CTRL_A: begin
                nxt.stage = ST_PAY;
                nxt.shift = cur_i.pay;
              end
              default: nxt.stage = ST_STOP;
            endcase
          end
        end
        ST_STOP: begin
          nxt.lines = stop_lines(cur_i.phase[1:0]);
          if (cur_i.phase >= 5'd2) begin
            nxt.stage = ST_IDLE;
            nxt.phase = 5'd0;
            nxt.busy  = 1'b0;
          end else begin
            nxt.phase = cur_i.phase + 5'd1;
          end
        end
        default: begin
          nxt.stage = ST_IDLE;
          nxt.phase = 5'd0;
          nxt.ins   = 2'd0;
          nxt.busy  = 1'b0;
        end
      endcase
    end
  end

  assign nxt_o = nxt;

  assign res_o = '{
    scl_level:  nxt.lines.scl,
    sda_level:  nxt.lines.sda,
    sda_driven: nxt.lines.drv,
    busy_res:   nxt.busy,
    nack_seen:  nxt.nack,
    send_taken: taken
  };

endmodule

`default_nettype wire

// ===== hdl/i2c_display_byte_writer.sv =====
// A result is registered at the edge that accepts its item, valid from the next cycle.
// One item per clock while in_ready_o is high; next state is one pass of the step unit.
// The input is taken while the result register is empty or being drained.
// Reset: asynchronous, active low; idle, lines high and driven, registers
// at 0x78 / 0x00 / 0x40, no result pending.
`default_nettype none

module i2c_display_byte_writer import i2cdbw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam state_t STATE_RESET = '{
    busy:    1'b0,
    stage:   ST_IDLE,
    phase:   5'd0,
    shift:   8'd0,
    pay:     8'd0,
    is_data: 1'b0,
    nack:    1'b0,
    ins:     2'd0,
    lines:   '{scl: 1'b1, sda: 1'b1, drv: 1'b1}
  };

  cfg_t     cfg_q;
  state_t   state_q, state_d;
  out_t     out_q, res_d;
  logic     out_valid_q;
  logic     in_fire;
  logic     cfg_wr;
  reg_idx_e reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dev_addr: DEV_ADDR_RESET, cmd_ctrl: CMD_CTRL_RESET,
                 dat_ctrl: DAT_CTRL_RESET};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEV_ADDR: cfg_q.dev_addr <= pwdata[7:0];
        REG_CMD_CTRL: cfg_q.cmd_ctrl <= pwdata[7:0];
        REG_DAT_CTRL: cfg_q.dat_ctrl <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_DEV_ADDR: prdata[7:0] = cfg_q.dev_addr;
      REG_CMD_CTRL: prdata[7:0] = cfg_q.cmd_ctrl;
      REG_DAT_CTRL: prdata[7:0] = cfg_q.dat_ctrl;
      default:      prdata      = '0;
    endcase
  end

  // sequencer step
  i2cdbw_step u_step (
    .cur_i  (state_q),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // transfer control: result register frees as it drains
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // busy and stage agree
  a_busy_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.busy == (state_q.stage != ST_IDLE))
    else $error("busy flag and stage disagree");

  // an accepted send starts the start condition
  a_send_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.command && !state_q.busy) |=>
      (state_q.stage == ST_START && state_q.phase == 5'd0))
    else $error("send did not start a transfer");

  // inserted stop only inside an acknowledge slot
  a_ins_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.ins != 2'd0) |->
      (state_q.stage == ST_ADDR_A || state_q.stage == ST_CTRL_A ||
       state_q.stage == ST_PAY_A))
    else $error("inserted stop outside acknowledge slot");

  // byte phase counter stays in range
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= BYTE_LAST_PHASE)
    else $error("phase counter out of range");

  // state moves only on an accepted item
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("state changed without a transfer");

endmodule

`default_nettype wire

// ===== tb/i2cdbw_tb_pkg.sv =====
// Scoreboard class with a line-phase predictor for the I2C display byte writer.
`timescale 1ns / 1ps

package i2cdbw_tb_pkg;
  import i2cdbw_pkg::*;

  class i2c_write_scoreboard;
    // register copies
    logic [7:0] dev_addr;
    logic [7:0] cmd_ctrl;
    logic [7:0] dat_ctrl;
    // sequencer copy
    bit         busy;
    stage_e     stg;
    logic [4:0] ph;
    logic [7:0] shreg;
    logic [7:0] pay;
    bit         is_dat;
    bit         nack;
    logic [1:0] ins;
    lines_t     ln;
    // results still owed by the block, oldest first
    out_t       expected_lines[$];
    int unsigned mismatches;

    function new();
      dev_addr   = DEV_ADDR_RESET;
      cmd_ctrl   = CMD_CTRL_RESET;
      dat_ctrl   = DAT_CTRL_RESET;
      busy       = 1'b0;
      stg        = ST_IDLE;
      ph         = '0;
      shreg      = '0;
      pay        = '0;
      is_dat     = 1'b0;
      nack       = 1'b0;
      ins        = '0;
      ln         = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [7:0] v);
      case (idx)
        REG_DEV_ADDR: dev_addr = v;
        REG_CMD_CTRL: cmd_ctrl = v;
        REG_DAT_CTRL: dat_ctrl = v;
        default: ;
      endcase
    endfunction

    function bit in_transfer();
      return busy;
    endfunction

    function int unsigned outstanding();
      return expected_lines.size();
    endfunction

    function void set_lines(bit c, bit d, bit v);
      ln.scl = c;
      ln.sda = d;
      ln.drv = v;
    endfunction

    // stop condition: clock low/data low, clock high, data high
    function void stop_level(logic [1:0] n);
      case (n)
        2'd0:    set_lines(1'b0, 1'b0, 1'b1);
        2'd1:    set_lines(1'b1, 1'b0, 1'b1);
        default: set_lines(1'b1, 1'b1, 1'b1);
      endcase
    endfunction

    // setup phase, then 8 MSB-first bits of 3 phases each
    function void shift_phase(stage_e ack_st);
      int q;
      if (ph == 0) begin
        set_lines(1'b0, 1'b0, 1'b1);
      end else begin
        q = (int'(ph) - 1) % 3;
        if (q == 0) set_lines(1'b0, shreg[7], 1'b1);
        else if (q == 1) set_lines(1'b1, ln.sda, 1'b1);
        else begin
          set_lines(1'b0, ln.sda, 1'b1);
          shreg = shreg << 1;
        end
      end
      if (ph >= BYTE_LAST_PHASE) begin
        stg = ack_st;
        ph  = '0;
      end else begin
        ph = ph + 5'd1;
      end
    endfunction

    // acknowledge slot; a NACK slips a stop in before the clock-low phase
    function void ack_slot(bit sda_in);
      if (ins != 0) begin
        stop_level(ins - 2'd1);
        ins = (ins == 2'd3) ? 2'd0 : ins + 2'd1;
        return;
      end
      if (ph == 0) begin
        set_lines(1'b1, 1'b1, 1'b0);
        if (sda_in) begin
          nack = 1'b1;
          ins  = 2'd1;
        end
        ph = 5'd1;
        return;
      end
      set_lines(1'b0, ln.sda, ln.drv);
      ph = '0;
      case (stg)
        ST_ADDR_A: begin
          stg   = ST_CTRL;
          shreg = is_dat ? dat_ctrl : cmd_ctrl;
        end
        ST_CTRL_A: begin
          stg   = ST_PAY;
          shreg = pay;
        end
        default: stg = ST_STOP;
      endcase
    endfunction

    function void line_tick(bit sda_in);
      case (stg)
        ST_START: begin
          if (ph == 0) begin
            set_lines(1'b1, 1'b1, 1'b1);
            ph = 5'd1;
          end else if (ph == 1) begin
            set_lines(1'b1, 1'b0, 1'b1);
            ph = 5'd2;
          end else begin
            set_lines(1'b0, 1'b0, 1'b1);
            stg   = ST_ADDR;
            ph    = '0;
            shreg = dev_addr;
          end
        end
        ST_ADDR: shift_phase(ST_ADDR_A);
        ST_CTRL: shift_phase(ST_CTRL_A);
        ST_PAY:  shift_phase(ST_PAY_A);
        ST_ADDR_A, ST_CTRL_A, ST_PAY_A: ack_slot(sda_in);
        ST_STOP: begin
          stop_level(ph[1:0]);
          if (ph >= 2) begin
            stg  = ST_IDLE;
            ph   = '0;
            busy = 1'b0;
          end else begin
            ph = ph + 5'd1;
          end
        end
        default: begin
          stg  = ST_IDLE;
          ph   = '0;
          ins  = '0;
          busy = 1'b0;
        end
      endcase
    endfunction

    // accepted input item: advance the copy and queue its result
    function void note(in_t it);
      out_t r;
      bit   taken;
      taken = 1'b0;
      if (it.command) begin
        if (!busy) begin
          pay    = it.payload_byte;
          is_dat = it.is_data;
          nack   = 1'b0;
          ins    = '0;
          busy   = 1'b1;
          stg    = ST_START;
          ph     = '0;
          taken  = 1'b1;
        end
      end else if (busy) begin
        line_tick(it.sda_in);
      end
      r.scl_level  = ln.scl;
      r.sda_level  = ln.sda;
      r.sda_driven = ln.drv;
      r.busy_res   = busy;
      r.nack_seen  = nack;
      r.send_taken = taken;
      expected_lines.push_back(r);
    endfunction

    function void cmp_field(string name, bit want, bit got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // accepted result against the oldest expectation
    function void check(out_t got);
      out_t want;
      if (expected_lines.size() == 0) begin
        $error("result with no expectation waiting");
        mismatches++;
        return;
      end
      want = expected_lines.pop_front();
      cmp_field("scl_level", want.scl_level, got.scl_level);
      cmp_field("sda_level", want.sda_level, got.sda_level);
      cmp_field("sda_driven", want.sda_driven, got.sda_driven);
      cmp_field("busy_res", want.busy_res, got.busy_res);
      cmp_field("nack_seen", want.nack_seen, got.nack_seen);
      cmp_field("send_taken", want.send_taken, got.send_taken);
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for the I2C display byte writer: drives items and registers, checks results.
`timescale 1ns / 1ps

module tb_top;
  import i2cdbw_pkg::*;
  import i2cdbw_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  i2c_write_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  i2c_display_byte_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // result side: check each transfer, then roll the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(out_data_o);
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // run length guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_t tick_item(bit sda);
    in_t t;
    t.command      = 1'b0;
    t.is_data      = 1'($urandom_range(0, 1));
    t.payload_byte = 8'($urandom_range(0, 255));
    t.sda_in       = sda;
    return t;
  endfunction

  function automatic in_t send_req(bit d, logic [7:0] p);
    in_t t;
    t.command      = 1'b1;
    t.is_data      = d;
    t.payload_byte = p;
    t.sda_in       = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // extremes now and then, otherwise any byte
  function automatic logic [7:0] reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one item on the input channel; valid stays high after the transfer
  task automatic push_item(in_t it);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(it);
    items_sent++;
  endtask

  // hold off input until every owed result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(reg_idx_e idx, logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'b0, want}) begin
      $error("prdata reg %s: expected %0h, got %0h", idx.name(), want, prdata);
      sb.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] dev, logic [7:0] cmd, logic [7:0] dat);
    settle();
    apb_write(REG_DEV_ADDR, dev);
    apb_write(REG_CMD_CTRL, cmd);
    apb_write(REG_DAT_CTRL, dat);
    apb_read_check(REG_DEV_ADDR, dev);
    apb_read_check(REG_CMD_CTRL, cmd);
    apb_read_check(REG_DAT_CTRL, dat);
  endtask

  // tick until the write is over; noise is sends that must be ignored
  task automatic finish_write(int unsigned nack_pct, int unsigned noise_pct);
    while (sb.in_transfer()) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_item(send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
      else
        push_item(tick_item($urandom_range(0, 99) < nack_pct));
    end
  endtask

  task automatic write_byte(bit d, logic [7:0] p, int unsigned nack_pct,
                            int unsigned noise_pct);
    push_item(send_req(d, p));
    finish_write(nack_pct, noise_pct);
  endtask

  initial begin
    int unsigned target;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    apb_read_check(REG_DEV_ADDR, DEV_ADDR_RESET);
    apb_read_check(REG_CMD_CTRL, CMD_CTRL_RESET);
    apb_read_check(REG_DAT_CTRL, DAT_CTRL_RESET);

    snd_idle = 7;
    rcv_idle = 86;

    // ticks while idle change nothing
    push_item(tick_item(1'b0));
    push_item(tick_item(1'b1));
    // data write, NACK in every slot, plus a send while busy
    push_item(send_req(1'b1, 8'hFF));
    push_item(send_req(1'b0, 8'h00));
    finish_write(100, 0);
    // command write, clean ACKs
    write_byte(1'b0, 8'h00, 0, 0);
    // register extremes, both control bytes
    set_regs(8'hFF, 8'h00, 8'hFF);
    write_byte(1'b1, 8'h5A, 0, 0);
    write_byte(1'b0, 8'hA5, 30, 0);
    set_regs(8'h00, 8'hFF, 8'h00);
    write_byte(1'b0, 8'hFF, 0, 0);
    write_byte(1'b1, 8'h01, 50, 0);

    // random writes under three idling patterns
    for (int m = 0; m < 3; m++) begin
      snd_idle = (m == 0) ? 7 : (m == 1) ? 86 : 0;
      rcv_idle = (m == 0) ? 86 : (m == 1) ? 7 : 0;
      target   = items_sent + 300;
      while (items_sent < target) begin
        if ($urandom_range(0, 5) == 0) set_regs(reg_value(), reg_value(), reg_value());
        repeat ($urandom_range(0, 2)) push_item(tick_item(1'($urandom_range(0, 1))));
        write_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 3) == 0) ? 60 : 5, 4);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
